### hdl/tdq_pkg.sv
// ----------------------------------------------------------------------------
// tdq_pkg: shared types and codes for the timer delay queue
// Opcodes, reply kinds and the controller/datapath command and status words.
// ----------------------------------------------------------------------------
`default_nettype none
package tdq_pkg;
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_TIME  = 3'd1;
    localparam logic [2:0] OP_DELAY = 3'd2;
    localparam logic [2:0] OP_UNTIL = 3'd3;

    localparam logic [1:0] KIND_WAKE   = 2'd0;
    localparam logic [1:0] KIND_TIME   = 2'd1;
    localparam logic [1:0] KIND_BADREQ = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    typedef struct packed {
        logic load;       // capture input word
        logic tick;       // advance tick count
        logic scan_start; // start insert scan from tail
        logic scan_step;  // move one entry toward head
        logic write_new;  // write new entry at scan position
        logic pop;        // drop head entry into the hold register
        logic out_load;   // load output register
        logic [1:0] kind;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic [2:0] opcode;
        logic       full;
        logic       head_due;   // head entry wake <= count
        logic       scan_done;  // insert position found
        logic       out_busy;
    } t_sts;
endpackage
`default_nettype wire

### hdl/tdq_datapath.sv
// ----------------------------------------------------------------------------
// tdq_datapath: tick counter, sorted queue ring and output register
// The queue is a ring in a RAM, read one entry per cycle; tdq_ram follows.
// ----------------------------------------------------------------------------
`default_nettype none
module tdq_datapath #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [2:0]    i_opcode,
    input  wire logic [7:0]    i_task_id,
    input  wire logic [31:0]   i_tick_amount,
    input  wire tdq_pkg::t_cmd i_cmd,
    output tdq_pkg::t_sts      o_sts,
    input  wire logic          i_out_take,
    output logic               o_valid,
    output logic [1:0]         o_reply_kind,
    output logic [7:0]         o_reply_task,
    output logic [31:0]        o_reply_value,
    output logic               o_last_of_run
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int RAM_DEPTH = 1 << IW;

    logic [31:0]   r_count;
    logic [CW-1:0] r_occ;
    logic [CW-1:0] r_pos;
    logic [IW-1:0] r_head;
    logic [7:0]    r_hold_id;
    logic [2:0]    r_op;
    logic [7:0]    r_task;
    logic [31:0]   r_amt;
    logic [31:0]   w_new_wake;
    logic [IW-1:0] w_rd_off;
    logic [IW-1:0] w_raddr;
    logic [IW-1:0] w_waddr;
    logic          w_we;
    logic [39:0]   w_wdata;
    logic [39:0]   w_rdata;
    logic [31:0]   w_rd_wake;
    logic [7:0]    w_rd_id;

    assign w_new_wake = (r_op == tdq_pkg::OP_DELAY) ? r_count + r_amt : r_amt;
    assign w_rd_wake  = w_rdata[39:8];
    assign w_rd_id    = w_rdata[7:0];

    // read the tail on scan start, the entry below the next slot while
    // scanning, the entry after the head on pop, otherwise the head
    always_comb begin
        if (i_cmd.scan_start)     w_rd_off = IW'(r_occ - CW'(1));
        else if (i_cmd.scan_step) w_rd_off = IW'(r_pos - CW'(2));
        else if (i_cmd.pop)       w_rd_off = IW'(1);
        else                      w_rd_off = '0;
    end

    assign w_raddr = r_head + w_rd_off;
    assign w_waddr = r_head + IW'(r_pos);
    assign w_we    = i_cmd.scan_step | i_cmd.write_new;
    // shift the larger entry up one place while searching
    assign w_wdata = i_cmd.write_new ? {w_new_wake, r_task} : w_rdata;

    tdq_ram #(.WIDTH(40), .DEPTH(RAM_DEPTH)) u_queue_ram (
        .i_clk,
        .i_we(w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_occ   <= '0;
            r_head  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cmd.tick) r_count <= r_count + 32'd1;
            if (i_cmd.write_new) r_occ <= r_occ + CW'(1);
            if (i_cmd.pop) begin
                r_occ  <= r_occ - CW'(1);
                r_head <= r_head + IW'(1);
            end
            if (i_cmd.out_load) o_valid <= 1'b1;
            else if (i_out_take) o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_task <= i_task_id;
            r_amt  <= i_tick_amount;
        end
        if (i_cmd.scan_start) r_pos <= r_occ;
        if (i_cmd.scan_step) r_pos <= r_pos - CW'(1);
        if (i_cmd.pop) r_hold_id <= w_rd_id;
        if (i_cmd.out_load) begin
            o_reply_kind  <= i_cmd.kind;
            o_reply_task  <= (i_cmd.kind == tdq_pkg::KIND_WAKE) ? r_hold_id : r_task;
            o_reply_value <= (i_cmd.kind == tdq_pkg::KIND_TIME) ? r_count : 32'd0;
            o_last_of_run <= i_cmd.last;
        end
    end

    always_comb begin
        o_sts.opcode    = r_op;
        o_sts.full      = (r_occ == CW'(QUEUE_DEPTH));
        o_sts.head_due  = (r_occ != '0) && (w_rd_wake <= r_count);
        o_sts.scan_done = (r_pos == '0) || !(w_rd_wake > w_new_wake);
        o_sts.out_busy  = o_valid && !i_out_take;
    end
endmodule

// generic single-port-write RAM with registered read
module tdq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/tdq_ctrl.sv
// ----------------------------------------------------------------------------
// tdq_ctrl: sequencer for the timer delay queue
// Decodes each word and steps the datapath through tick, query and insert.
// ----------------------------------------------------------------------------
`default_nettype none
module tdq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire tdq_pkg::t_sts i_sts,
    output tdq_pkg::t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_RELEASE, S_NEXT, S_SCAN, S_REPLY
    } t_state;
    t_state r_state, n_state;
    logic [1:0] w_kind;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        unique case (i_sts.opcode) inside
            tdq_pkg::OP_TIME:                     w_kind = tdq_pkg::KIND_TIME;
            tdq_pkg::OP_DELAY, tdq_pkg::OP_UNTIL: w_kind = tdq_pkg::KIND_FULL;
            default:                              w_kind = tdq_pkg::KIND_BADREQ;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.opcode == tdq_pkg::OP_TICK) begin
                    o_cmd.tick = 1'b1;
                    n_state = S_RELEASE;
                end else if ((i_sts.opcode == tdq_pkg::OP_DELAY ||
                              i_sts.opcode == tdq_pkg::OP_UNTIL) && !i_sts.full) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_RELEASE: begin
                // take the first due sleeper into the hold register
                if (!i_sts.head_due) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                // send the held sleeper; it is last unless the new head is due
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.kind = tdq_pkg::KIND_WAKE;
                    o_cmd.last = !i_sts.head_due;
                    if (i_sts.head_due) o_cmd.pop = 1'b1;
                    else                n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.write_new = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_REPLY: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.kind = w_kind;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

### hdl/timer_delay_queue_unit.sv
// ----------------------------------------------------------------------------
// timer_delay_queue_unit: tick counter with a sorted queue of sleeping tasks
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_stall) carries a request word: opcode, task id,
// tick amount. Output channel (o_valid/i_stall) carries reply words.
// One request is in work at a time; o_stall is high from the cycle after
// acceptance until the request is done, so the next request waits for it.
// Query, bad opcode and full-queue insert give one word, loaded into the
// output register in the reply state after decode.
// A tick advances the count, then due sleepers leave one word per cycle in
// wake order while the receiver does not stall, the last flagged by
// o_last_of_run; no word when nothing is due.
// The queue is a ring in a RAM; an insert walks in from the tail one entry
// per cycle and gives no word.
// When the receiver stalls the output register holds and the next word
// waits. Reset zeroes the tick count and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module timer_delay_queue_unit #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [7:0]  i_task_id,
    input  wire logic [31:0] i_tick_amount,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_reply_kind,
    output logic [7:0]       o_reply_task,
    output logic [31:0]      o_reply_value,
    output logic             o_last_of_run
);
    tdq_pkg::t_cmd w_cmd;
    tdq_pkg::t_sts w_sts;

    tdq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    tdq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_opcode, .i_task_id, .i_tick_amount,
        .i_cmd(w_cmd), .o_sts(w_sts), .i_out_take(!i_stall),
        .o_valid, .o_reply_kind, .o_reply_task, .o_reply_value, .o_last_of_run
    );
endmodule
`default_nettype wire

### hdl/tdq_checker.sv
// ----------------------------------------------------------------------------
// tdq_checker: port-level checks for the timer delay queue
// ----------------------------------------------------------------------------
`default_nettype none
module tdq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_reply_kind,
    input wire logic [31:0] o_reply_value,
    input wire logic        o_last_of_run
);
    // a stalled reply word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reply_value))
        else $error("reply changed under stall");
    // only time replies carry a value
    a_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reply_kind != tdq_pkg::KIND_TIME |-> o_reply_value == 32'd0)
        else $error("nonzero value");
    // replies other than wake end their run
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reply_kind != tdq_pkg::KIND_WAKE |-> o_last_of_run)
        else $error("single reply not last");
    // an accepted word blocks the next one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted back to back");
endmodule

bind timer_delay_queue_unit tdq_checker u_tdq_checker (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
    .o_reply_kind, .o_reply_value, .o_last_of_run
);
`default_nettype wire
